/* hw/rtl/asg_pkg.sv */
// ----------------------------------------------------------------------------
// asg_pkg
// shared types, constants and register codes of the autostereogram row unit
// ----------------------------------------------------------------------------
package asg_pkg;

    localparam int MAX_WIDTH_DEF    = 1024;
    localparam int COLOUR_BITS_DEF  = 8;
    localparam int DEPTH_LEVELS_DEF = 32;

    localparam int COLOUR_W = 8;
    localparam int DEPTH_W  = 5;
    localparam int PERIOD_W = 10;
    localparam int COPIES_W = 5;
    localparam int CMP_W    = 16;

    typedef logic [COLOUR_W-1:0] colour_t;
    typedef logic [DEPTH_W-1:0]  depth_t;
    typedef logic [PERIOD_W-1:0] period_t;
    typedef logic [COPIES_W-1:0] copies_t;

    localparam period_t PERIOD_RST = period_t'(64);
    localparam copies_t COPIES_RST = copies_t'(10);

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef logic [0:0] reg_idx_t;
    localparam reg_idx_t REG_BAND_PERIOD = 1'b0;
    localparam reg_idx_t REG_BAND_COPIES = 1'b1;

    typedef enum logic [1:0] {
        KIND_ZERO  = 2'b00,
        KIND_NOISE = 2'b01,
        KIND_COPY  = 2'b10
    } kind_t;

    typedef struct packed {
        logic  valid;
        logic  last;
        logic  store;
        kind_t kind;
    } pix_ctl_t;

endpackage

/* hw/rtl/autostereogram_row_generator_unit.sv */
// ----------------------------------------------------------------------------
// autostereogram_row_generator_unit
// random-dot autostereogram row generator, one pixel per beat
// ----------------------------------------------------------------------------
// an input beat passes the depth stage, colour stage and output registers before its output beat is valid
// throughput: one pixel per cycle while the output beat is not held, with registered depth and colour line reads
// the three-stage pipeline stalls as a whole only while the output beat is held
// reset: column counter cleared, band period 64, band count 10, pipeline empty
// line memories are not cleared; entries are used only after being written in a row
// ----------------------------------------------------------------------------
module autostereogram_row_generator_unit
#(
    parameter int MAX_WIDTH    = asg_pkg::MAX_WIDTH_DEF,
    parameter int COLOUR_BITS  = asg_pkg::COLOUR_BITS_DEF,
    parameter int DEPTH_LEVELS = asg_pkg::DEPTH_LEVELS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [15:0]                     s_axis_tdata,   // noise_colour, scene_depth, pad
    input  logic                            s_axis_tlast,   // end_of_row
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [7:0]                      m_axis_tdata,   // pixel_colour
    output logic                            m_axis_tlast,   // row_done
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [asg_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [asg_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [asg_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    localparam int AW = $clog2(MAX_WIDTH);

    asg_pkg::period_t   band_period;
    asg_pkg::copies_t   band_copies;
    logic               en;
    asg_pkg::pix_ctl_t  p1_ctl;
    logic [AW-1:0]      p1_col;
    logic [AW-1:0]      p1_base;
    asg_pkg::colour_t   p1_noise;
    asg_pkg::depth_t    p1_depth;

    assign s_axis_tready = en;

    asg_cfg_regs u_cfg
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .band_period (band_period),
        .band_copies (band_copies)
    );

    asg_depth_stage
    #(
        .MAX_WIDTH    (MAX_WIDTH),
        .COLOUR_BITS  (COLOUR_BITS),
        .DEPTH_LEVELS (DEPTH_LEVELS)
    )
    u_depth
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (s_axis_tvalid),
        .noise_colour (s_axis_tdata[7:0]),
        .scene_depth  (s_axis_tdata[12:8]),
        .end_of_row   (s_axis_tlast),
        .band_period  (band_period),
        .band_copies  (band_copies),
        .p1_ctl       (p1_ctl),
        .p1_col       (p1_col),
        .p1_base      (p1_base),
        .p1_noise     (p1_noise),
        .p1_depth     (p1_depth)
    );

    asg_colour_stage
    #(
        .MAX_WIDTH (MAX_WIDTH)
    )
    u_colour
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .p1_ctl       (p1_ctl),
        .p1_col       (p1_col),
        .p1_base      (p1_base),
        .p1_noise     (p1_noise),
        .p1_depth     (p1_depth),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .pixel_colour (m_axis_tdata),
        .row_done     (m_axis_tlast)
    );

endmodule

/* hw/rtl/asg_cfg_regs.sv */
// ----------------------------------------------------------------------------
// asg_cfg_regs
// apb register file holding band period and band count
// ----------------------------------------------------------------------------
module asg_cfg_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [asg_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [asg_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [asg_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output asg_pkg::period_t                 band_period,
    output asg_pkg::copies_t                 band_copies
);

    asg_pkg::period_t  period_reg;
    asg_pkg::copies_t  copies_reg;
    asg_pkg::reg_idx_t reg_idx;
    logic              wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= asg_pkg::PERIOD_RST;
            copies_reg <= asg_pkg::COPIES_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                asg_pkg::REG_BAND_PERIOD: period_reg <= pwdata[asg_pkg::PERIOD_W-1:0];
                asg_pkg::REG_BAND_COPIES: copies_reg <= pwdata[asg_pkg::COPIES_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            asg_pkg::REG_BAND_PERIOD:
                prdata = asg_pkg::APB_DATA_W'(period_reg);
            asg_pkg::REG_BAND_COPIES:
                prdata = asg_pkg::APB_DATA_W'(copies_reg);
            default:
                prdata = '0;
        endcase
    end

    assign band_period = period_reg;
    assign band_copies = copies_reg;

endmodule

/* hw/rtl/asg_depth_stage.sv */
// ----------------------------------------------------------------------------
// asg_depth_stage
// column counter, band classification and depth line memory
// ----------------------------------------------------------------------------
module asg_depth_stage
#(
    parameter int MAX_WIDTH    = asg_pkg::MAX_WIDTH_DEF,
    parameter int COLOUR_BITS  = asg_pkg::COLOUR_BITS_DEF,
    parameter int DEPTH_LEVELS = asg_pkg::DEPTH_LEVELS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  asg_pkg::colour_t                noise_colour,
    input  asg_pkg::depth_t                 scene_depth,
    input  logic                            end_of_row,
    input  asg_pkg::period_t                band_period,
    input  asg_pkg::copies_t                band_copies,
    output asg_pkg::pix_ctl_t               p1_ctl,
    output logic [$clog2(MAX_WIDTH)-1:0]    p1_col,
    output logic [$clog2(MAX_WIDTH)-1:0]    p1_base,
    output asg_pkg::colour_t                p1_noise,
    output asg_pkg::depth_t                 p1_depth
);

    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int CW   = AW + 1;
    localparam int DMAX = DEPTH_LEVELS - 1;
    localparam asg_pkg::colour_t NOISE_MASK = (COLOUR_BITS >= asg_pkg::COLOUR_W) ?
        {asg_pkg::COLOUR_W{1'b1}} : asg_pkg::colour_t'((1 << COLOUR_BITS) - 1);
    localparam asg_pkg::depth_t DEPTH_CAP = (DMAX > (1 << asg_pkg::DEPTH_W) - 1) ?
        {asg_pkg::DEPTH_W{1'b1}} : asg_pkg::depth_t'(DMAX);

    logic [CW-1:0]              col_reg;
    logic [CW-1:0]              col_next;
    asg_pkg::pix_ctl_t          ctl_reg;
    asg_pkg::pix_ctl_t          ctl_next;
    logic [AW-1:0]              col_p1_reg;
    logic [AW-1:0]              base_p1_reg;
    asg_pkg::colour_t           noise_p1_reg;
    asg_pkg::depth_t            depth_rd_reg;
    asg_pkg::depth_t            depth_mem [MAX_WIDTH];

    logic                       accept;
    logic                       sat;
    logic [asg_pkg::CMP_W-1:0]  x_w;
    logic [asg_pkg::CMP_W-1:0]  per_w;
    logic [asg_pkg::CMP_W-1:0]  limit_w;
    logic [asg_pkg::CMP_W-1:0]  base_w;
    logic [AW-1:0]              base;
    asg_pkg::depth_t            depth_cl;

    assign accept  = en && in_valid;
    assign sat     = (col_reg >= CW'(MAX_WIDTH));
    assign x_w     = asg_pkg::CMP_W'(col_reg);
    assign per_w   = asg_pkg::CMP_W'(band_period);
    assign limit_w = asg_pkg::CMP_W'(band_period) * asg_pkg::CMP_W'(band_copies);
    assign base_w  = x_w - per_w;
    assign base    = base_w[AW-1:0];
    assign depth_cl = (scene_depth > DEPTH_CAP) ? DEPTH_CAP : scene_depth;

    always_comb
    begin
        ctl_next.valid = accept;
        ctl_next.last  = end_of_row;
        ctl_next.store = !sat;
        if (sat || x_w >= limit_w)
        begin
            ctl_next.kind = asg_pkg::KIND_ZERO;
        end
        else if (x_w < per_w)
        begin
            ctl_next.kind = asg_pkg::KIND_NOISE;
        end
        else
        begin
            ctl_next.kind = asg_pkg::KIND_COPY;
        end
    end

    always_comb
    begin
        col_next = col_reg;
        if (accept)
        begin
            if (!sat)
            begin
                col_next = col_reg + CW'(1);
            end
            if (end_of_row)
            begin
                col_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            ctl_reg <= '0;
        end
        else if (en)
        begin
            col_reg <= col_next;
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            col_p1_reg   <= col_reg[AW-1:0];
            base_p1_reg  <= base;
            noise_p1_reg <= noise_colour & NOISE_MASK;
        end
    end

    // depth line: write current column, read source band column
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (accept && !sat)
            begin
                depth_mem[col_reg[AW-1:0]] <= depth_cl;
            end
            depth_rd_reg <= depth_mem[base];
        end
    end

    assign p1_ctl   = ctl_reg;
    assign p1_col   = col_p1_reg;
    assign p1_base  = base_p1_reg;
    assign p1_noise = noise_p1_reg;
    assign p1_depth = depth_rd_reg;

endmodule

/* hw/rtl/asg_colour_stage.sv */
// ----------------------------------------------------------------------------
// asg_colour_stage
// source column lookup in the colour line memory, forwarding and output beat
// ----------------------------------------------------------------------------
module asg_colour_stage
#(
    parameter int MAX_WIDTH = asg_pkg::MAX_WIDTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    output logic                            en,
    input  asg_pkg::pix_ctl_t               p1_ctl,
    input  logic [$clog2(MAX_WIDTH)-1:0]    p1_col,
    input  logic [$clog2(MAX_WIDTH)-1:0]    p1_base,
    input  asg_pkg::colour_t                p1_noise,
    input  asg_pkg::depth_t                 p1_depth,
    output logic                            out_valid,
    input  logic                            out_ready,
    output asg_pkg::colour_t                pixel_colour,
    output logic                            row_done
);

    localparam int AW = $clog2(MAX_WIDTH);

    asg_pkg::pix_ctl_t  ctl_p2_reg;
    asg_pkg::pix_ctl_t  ctl_p2_next;
    logic [AW-1:0]      col_p2_reg;
    asg_pkg::colour_t   noise_p2_reg;
    logic               fwd_hit_reg;
    asg_pkg::colour_t   fwd_val_reg;
    asg_pkg::colour_t   colour_rd_reg;
    logic               out_valid_reg;
    asg_pkg::colour_t   out_colour_reg;
    logic               out_last_reg;
    asg_pkg::colour_t   colour_mem [MAX_WIDTH];

    logic [AW:0]        src;
    logic               src_ok;
    logic               fwd_hit;
    asg_pkg::colour_t   p2_colour;

    assign en     = !out_valid_reg || out_ready;
    assign src    = (AW+1)'(p1_base) + (AW+1)'(p1_depth);
    assign src_ok = (src < (AW+1)'(p1_col));
    assign fwd_hit = ctl_p2_reg.valid && ctl_p2_reg.store && (src == (AW+1)'(col_p2_reg));

    always_comb
    begin
        ctl_p2_next = p1_ctl;
        if (p1_ctl.kind == asg_pkg::KIND_COPY && !src_ok)
        begin
            ctl_p2_next.kind = asg_pkg::KIND_ZERO;
        end
    end

    always_comb
    begin
        case (ctl_p2_reg.kind)
            asg_pkg::KIND_NOISE: p2_colour = noise_p2_reg;
            asg_pkg::KIND_COPY:  p2_colour = fwd_hit_reg ? fwd_val_reg : colour_rd_reg;
            default:             p2_colour = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_p2_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            ctl_p2_reg    <= ctl_p2_next;
            out_valid_reg <= ctl_p2_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            col_p2_reg   <= p1_col;
            noise_p2_reg <= p1_noise;
            fwd_hit_reg  <= fwd_hit;
            fwd_val_reg  <= p2_colour;
            if (ctl_p2_reg.valid)
            begin
                out_colour_reg <= p2_colour;
                out_last_reg   <= ctl_p2_reg.last;
            end
        end
    end

    // colour line: read source column, write back the finished column
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            colour_rd_reg <= colour_mem[src[AW-1:0]];
            if (ctl_p2_reg.valid && ctl_p2_reg.store)
            begin
                colour_mem[col_p2_reg] <= p2_colour;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_colour = out_colour_reg;
    assign row_done     = out_last_reg;

endmodule
